>>> design/pidc_pkg.sv
// Shared constants and codes of the clamped PID controller.
package pidc_pkg;

  // Fixed field widths.
  localparam int KIND_W    = 2;
  localparam int TIME_W    = 32;
  localparam int PERIOD_W  = 16;
  localparam int CFG_IDX_W = 3;

  // Fractional bits of the gain format and the product magnitude limit exponent.
  localparam int FRAC_BITS = 16;
  localparam int SAT_EXP   = 60;

  // Register reset values.
  localparam longint PROP_RST   = 65536;
  localparam longint HIGH_RST   = 16711680;
  localparam int     PERIOD_RST = 100;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP   = 3'd0,
    CFG_INTEG  = 3'd1,
    CFG_DERIV  = 3'd2,
    CFG_LOW    = 3'd3,
    CFG_HIGH   = 3'd4,
    CFG_PERIOD = 3'd5,
    CFG_REV    = 3'd6
  } cfg_idx_e;

  // Item kinds.
  typedef enum logic [KIND_W-1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_AUTO   = 2'd1,
    KIND_MANUAL = 2'd2
  } kind_e;

endpackage

>>> design/pidc_in_if.sv
// Input channel of the PID controller: valid, ready and one item.
interface pidc_in_if #(
  parameter int VALUE_WIDTH = 32
);
  logic                               valid;
  logic                               ready;
  logic [pidc_pkg::KIND_W-1:0]        kind;
  logic [pidc_pkg::TIME_W-1:0]        now_ms;
  logic signed [VALUE_WIDTH-1:0]      measurement;
  logic signed [VALUE_WIDTH-1:0]      setpoint;
  logic signed [VALUE_WIDTH-1:0]      manual_output;

  modport source (output valid, kind, now_ms, measurement, setpoint, manual_output,
                  input ready);
  modport sink   (input valid, kind, now_ms, measurement, setpoint, manual_output,
                  output ready);
endinterface

>>> design/pidc_out_if.sv
// Output channel of the PID controller: valid, ready and one result.
interface pidc_out_if #(
  parameter int VALUE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] drive;
  logic                          updated;
  logic                          automatic_res;

  modport source (output valid, drive, updated, automatic_res, input ready);
  modport sink   (input valid, drive, updated, automatic_res, output ready);
endinterface

>>> design/pid_controller_clamped_unit.sv
// Top level of the clamped PID controller with derivative on measurement.
//
//   Port      | Dir | Handshake        | Contents
//   in_if     | in  | valid/ready      | kind, now_ms, measurement, setpoint, manual_output
//   out_if    | out | valid/ready      | drive, updated, automatic_res
//   cfg_*_i   | in  | write enable     | register index and write data
//
// A mode item or a sample that causes no update goes from idle to the final state.
// An updating sample occupies the block through the bit-serial divider for the
// derivative, then three passes of the shared bit-serial gain multiplier. Reset
// clears the sequencer, controller state and configuration, not the payload
// registers. A new item is taken while a finished result waits in the output
// register; a stalled output holds the block in its final state until it frees.
module pid_controller_clamped_unit #(
  parameter int VALUE_WIDTH = 32,
  parameter int GAIN_WIDTH  = 24
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [pidc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [((VALUE_WIDTH > GAIN_WIDTH) ? VALUE_WIDTH : GAIN_WIDTH)-1:0] cfg_data_i,
  pidc_in_if.sink    in_if,
  pidc_out_if.source out_if
);

  localparam int VW   = VALUE_WIDTH;
  localparam int GW   = GAIN_WIDTH;
  localparam int EW   = VW + 1;
  localparam int SHW  = EW + GW - pidc_pkg::FRAC_BITS;
  localparam int RMW  = (SHW < pidc_pkg::SAT_EXP + 1) ? SHW : pidc_pkg::SAT_EXP + 1;
  localparam int TW   = RMW + 1;
  localparam int AW   = ((RMW > VW) ? RMW : VW) + 3;
  localparam int TMW  = pidc_pkg::TIME_W;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_DIV   = 6'b000010,
    ST_MUL_I = 6'b000100,
    ST_MUL_P = 6'b001000,
    ST_MUL_D = 6'b010000,
    ST_FIN   = 6'b100000
  } state_e;

  state_e st_q;

  // Configuration registers.
  logic [GW-1:0]                    kp_q, ki_q, kd_q;
  logic signed [VW-1:0]             low_q, high_q;
  logic [pidc_pkg::PERIOD_W-1:0]    period_q;
  logic                             rev_q;

  // Controller state.
  logic                             auto_q;
  logic                             first_q;
  logic signed [VW-1:0]             integ_q;
  logic signed [VW-1:0]             prev_q;
  logic [TMW-1:0]                   last_q;

  // Working registers of one update.
  logic signed [EW-1:0]             err_q;
  logic signed [EW-1:0]             diff_q;
  logic [EW-1:0]                    deriv_q;
  logic [TMW-1:0]                   dt_q;
  logic signed [AW-1:0]             acc_q;
  logic                             start_q;
  logic                             start_d;
  logic signed [VW-1:0]             res_drive_q;
  logic                             res_upd_q;

  // Output register.
  logic                             out_valid_q;
  logic signed [VW-1:0]             drive_q;
  logic                             upd_q;
  logic                             autores_q;

  logic                             in_acc;
  logic                             out_free;
  logic [TMW-1:0]                   elapsed;
  logic [TMW-1:0]                   dt_raw;
  logic                             due;
  logic [EW-1:0]                    err_mag;
  logic [EW-1:0]                    diff_mag;
  logic                             div_done;
  logic [EW-1:0]                    quo;
  logic                             mul_done;
  logic signed [TW-1:0]             term;
  logic [EW-1:0]                    mul_mag;
  logic [GW-1:0]                    mul_gain;
  logic                             mul_neg;
  logic signed [AW-1:0]             cl_in;
  logic signed [AW-1:0]             cl_lo, cl_hi;
  logic signed [VW-1:0]             cl_out;

  assign in_if.ready = (st_q == ST_IDLE);
  assign in_acc      = in_if.valid && (st_q == ST_IDLE);
  assign out_free    = !out_valid_q || out_if.ready;

  // Update timing and operand magnitudes.
  always_comb begin
    elapsed  = in_if.now_ms - last_q;
    due      = first_q || (elapsed >= TMW'(period_q));
    dt_raw   = first_q ? TMW'(period_q) : elapsed;
    err_mag  = err_q[EW-1] ? $unsigned(-err_q) : $unsigned(err_q);
    diff_mag = diff_q[EW-1] ? $unsigned(-diff_q) : $unsigned(diff_q);
  end

  // Start pulse for the divider or the multiplier as each step begins.
  always_comb begin
    start_d = 1'b0;
    unique case (st_q)
      ST_IDLE:  start_d = in_acc && (in_if.kind == pidc_pkg::KIND_SAMPLE) && auto_q && due;
      ST_DIV:   start_d = div_done;
      ST_MUL_I: start_d = mul_done;
      ST_MUL_P: start_d = mul_done;
      default:  start_d = 1'b0;
    endcase
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_mag  = err_mag;
    mul_gain = kp_q;
    mul_neg  = err_q[EW-1] ^ rev_q;
    case (st_q)
      ST_MUL_I: mul_gain = ki_q;
      ST_MUL_D: begin
        mul_mag  = deriv_q;
        mul_gain = kd_q;
        mul_neg  = diff_q[EW-1] ^ rev_q;
      end
      default: mul_gain = kp_q;
    endcase
  end

  // Shared clamp to the output limits; above the upper limit wins.
  always_comb begin
    case (st_q)
      ST_MUL_I: cl_in = AW'(integ_q) + AW'(term);
      ST_MUL_D: cl_in = acc_q - AW'(term);
      default:  cl_in = AW'(in_if.manual_output);
    endcase
    cl_lo = AW'(low_q);
    cl_hi = AW'(high_q);
    if (cl_in > cl_hi) begin
      cl_out = high_q;
    end else if (cl_in < cl_lo) begin
      cl_out = low_q;
    end else begin
      cl_out = VW'(cl_in);
    end
  end

  pidc_div #(
    .NUM_W (EW),
    .DEN_W (TMW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q && (st_q == ST_DIV)),
    .num_i   (diff_mag),
    .den_i   (dt_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  pidc_mul #(
    .MAG_W  (EW),
    .GAIN_W (GW),
    .TERM_W (TW)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q && (st_q != ST_DIV)),
    .mag_i   (mul_mag),
    .gain_i  (mul_gain),
    .neg_i   (mul_neg),
    .done_o  (mul_done),
    .term_o  (term)
  );

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q     <= GW'(pidc_pkg::PROP_RST);
      ki_q     <= '0;
      kd_q     <= '0;
      low_q    <= '0;
      high_q   <= VW'(pidc_pkg::HIGH_RST);
      period_q <= pidc_pkg::PERIOD_W'(pidc_pkg::PERIOD_RST);
      rev_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pidc_pkg::CFG_PROP:   kp_q     <= cfg_data_i[GW-1:0];
        pidc_pkg::CFG_INTEG:  ki_q     <= cfg_data_i[GW-1:0];
        pidc_pkg::CFG_DERIV:  kd_q     <= cfg_data_i[GW-1:0];
        pidc_pkg::CFG_LOW:    low_q    <= $signed(cfg_data_i[VW-1:0]);
        pidc_pkg::CFG_HIGH:   high_q   <= $signed(cfg_data_i[VW-1:0]);
        pidc_pkg::CFG_PERIOD: period_q <= cfg_data_i[pidc_pkg::PERIOD_W-1:0];
        pidc_pkg::CFG_REV:    rev_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Sequencer and controller state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      start_q     <= 1'b0;
      auto_q      <= 1'b0;
      first_q     <= 1'b1;
      integ_q     <= '0;
      prev_q      <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
      res_upd_q   <= 1'b0;
    end else begin
      start_q <= start_d;
      // The result register fills from the final step and empties on a handshake.
      if ((st_q == ST_FIN) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_if.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (st_q)
        ST_IDLE: begin
          if (in_acc) begin
            res_upd_q <= 1'b0;
            case (in_if.kind)
              pidc_pkg::KIND_AUTO: begin
                if (!auto_q) begin
                  integ_q <= cl_out;
                  prev_q  <= in_if.measurement;
                end
                auto_q <= 1'b1;
                st_q   <= ST_FIN;
              end
              pidc_pkg::KIND_MANUAL: begin
                auto_q <= 1'b0;
                st_q   <= ST_FIN;
              end
              pidc_pkg::KIND_SAMPLE: begin
                if (auto_q && due) begin
                  prev_q  <= in_if.measurement;
                  last_q  <= in_if.now_ms;
                  first_q <= 1'b0;
                  st_q    <= ST_DIV;
                end else begin
                  st_q <= ST_FIN;
                end
              end
              default: st_q <= ST_FIN;
            endcase
          end
        end
        ST_DIV: begin
          if (div_done) begin
            st_q <= ST_MUL_I;
          end
        end
        ST_MUL_I: begin
          if (mul_done) begin
            integ_q <= cl_out;
            st_q    <= ST_MUL_P;
          end
        end
        ST_MUL_P: begin
          if (mul_done) begin
            st_q <= ST_MUL_D;
          end
        end
        ST_MUL_D: begin
          if (mul_done) begin
            res_upd_q <= 1'b1;
            st_q      <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            st_q <= ST_IDLE;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  // Payload registers of an update and of the result.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      err_q       <= EW'(in_if.setpoint) - EW'(in_if.measurement);
      diff_q      <= EW'(in_if.measurement) - EW'(prev_q);
      dt_q        <= (dt_raw == '0) ? TMW'(1) : dt_raw;
      res_drive_q <= '0;
    end
    if ((st_q == ST_DIV) && div_done) begin
      deriv_q <= quo;
    end
    if ((st_q == ST_MUL_P) && mul_done) begin
      acc_q <= AW'(term) + AW'(integ_q);
    end
    if ((st_q == ST_MUL_D) && mul_done) begin
      res_drive_q <= cl_out;
    end
    if ((st_q == ST_FIN) && out_free) begin
      drive_q   <= res_drive_q;
      upd_q     <= res_upd_q;
      autores_q <= auto_q;
    end
  end

  assign out_if.valid         = out_valid_q;
  assign out_if.drive         = drive_q;
  assign out_if.updated       = upd_q;
  assign out_if.automatic_res = autores_q;

  // The multiplier reports a result only while the sequencer waits for one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (st_q == ST_MUL_I || st_q == ST_MUL_P || st_q == ST_MUL_D))
    else $error("multiplier finished outside a multiply step");

  // The divider reports a result only in the divide step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (st_q == ST_DIV))
    else $error("divider finished outside the divide step");

  // A result without an update carries a zero drive.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !upd_q) |-> (drive_q == '0))
    else $error("drive is nonzero on a result without update");

  // An updated drive lies within ordered limits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && upd_q && (low_q <= high_q)) |-> (drive_q >= low_q && drive_q <= high_q))
    else $error("updated drive outside the output limits");

endmodule

>>> design/pidc_div.sv
// Restoring divider that develops one quotient bit per cycle.
module pidc_div #(
  parameter int NUM_W = 33,
  parameter int DEN_W = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] rem_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   shifted;

  // Trial subtraction of the divisor from the partial remainder.
  always_comb begin
    shifted = {rem_q, num_q[NUM_W-1]};
    trial   = shifted - {1'b0, den_q};
  end

  // Control: count the quotient bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_W'(NUM_W - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(NUM_W - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Datapath: the dividend shifts out as the quotient shifts in.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      if (!trial[DEN_W]) begin
        rem_q <= trial[DEN_W-1:0];
        num_q <= {num_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_q <= shifted[DEN_W-1:0];
        num_q <= {num_q[NUM_W-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = num_q;

endmodule

>>> design/pidc_mul.sv
// Shift-and-add gain multiplier, one gain bit per cycle, with scaling and saturation.
module pidc_mul #(
  parameter int MAG_W  = 33,
  parameter int GAIN_W = 24,
  parameter int TERM_W = 42
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [MAG_W-1:0]         mag_i,
  input  logic [GAIN_W-1:0]        gain_i,
  input  logic                     neg_i,
  output logic                     done_o,
  output logic signed [TERM_W-1:0] term_o
);

  localparam int PW    = MAG_W + GAIN_W;
  localparam int SHW   = PW - pidc_pkg::FRAC_BITS;
  localparam int MW    = (SHW > pidc_pkg::SAT_EXP + 1) ? SHW : pidc_pkg::SAT_EXP + 1;
  localparam int RMW   = TERM_W - 1;
  localparam int CNT_W = (GAIN_W > 1) ? $clog2(GAIN_W) : 1;

  logic [PW-1:0]            acc_q;
  logic [MAG_W-1:0]         mag_q;
  logic [GAIN_W-1:0]        gain_q;
  logic                     neg_q;
  logic [CNT_W-1:0]         cnt_q;
  logic                     busy_q;
  logic                     fin_q;
  logic                     done_q;
  logic signed [TERM_W-1:0] term_q;
  logic [MW-1:0]            scaled;
  logic [MW-1:0]            capped;
  logic [RMW:0]             mag_ext;

  // Drop the fraction bits and hold the magnitude at the limit.
  always_comb begin
    scaled  = MW'(acc_q[PW-1:pidc_pkg::FRAC_BITS]);
    capped  = (scaled > (MW'(1) << pidc_pkg::SAT_EXP)) ? (MW'(1) << pidc_pkg::SAT_EXP)
                                                        : scaled;
    mag_ext = {1'b0, capped[RMW-1:0]};
  end

  // Control: one gain bit per cycle, then the final scaling registered through fin_q.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      fin_q  <= busy_q && (cnt_q == CNT_W'(GAIN_W - 1));
      done_q <= fin_q;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(GAIN_W - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Datapath: accumulate from the most significant gain bit down.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q  <= '0;
      mag_q  <= mag_i;
      gain_q <= gain_i;
      neg_q  <= neg_i;
    end else if (busy_q) begin
      acc_q  <= (acc_q << 1) + (gain_q[GAIN_W-1] ? PW'(mag_q) : '0);
      gain_q <= gain_q << 1;
    end
    if (fin_q) begin
      term_q <= neg_q ? -$signed(mag_ext) : $signed(mag_ext);
    end
  end

  assign done_o = done_q;
  assign term_o = term_q;

endmodule

>>> bench/pid_controller_clamped_unit_tb.sv
// Self-checking testbench of the clamped PID controller top level.
module pid_controller_clamped_unit_tb;

  localparam int VW = 32;
  localparam int GW = 24;
  localparam int CFG_W = (VW > GW) ? VW : GW;
  localparam int KW = pidc_pkg::KIND_W;
  localparam int TW = pidc_pkg::TIME_W;
  localparam int PW = pidc_pkg::PERIOD_W;
  localparam logic [KW-1:0] K_SAMPLE = pidc_pkg::KIND_SAMPLE;
  localparam logic [KW-1:0] K_AUTO = pidc_pkg::KIND_AUTO;
  localparam logic [KW-1:0] K_MANUAL = pidc_pkg::KIND_MANUAL;
  localparam logic [KW-1:0] KIND_SPARE = 2'd3;
  localparam longint unsigned MAG_LIMIT = 64'd1 << pidc_pkg::SAT_EXP;
  localparam logic [GW-1:0] GAIN_MAX = '1;
  localparam logic signed [VW-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VW-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VW-1:0] HIGH_VAL = VW'(pidc_pkg::HIGH_RST);
  localparam logic [VW-1:0] ONE_Q16 = 32'd65536;
  localparam int RANDOM_PHASES = 7;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int DRAIN_CYCLES = 150;

  typedef struct packed {
    logic [KW-1:0] kind;
    logic [TW-1:0] now;
    logic signed [VW-1:0] meas;
    logic signed [VW-1:0] sp;
    logic signed [VW-1:0] man;
  } pid_item_t;

  typedef struct packed {
    logic signed [VW-1:0] drive;
    logic updated;
    logic mode_auto;
  } pid_result_t;

  typedef struct packed {
    pid_item_t item;
    logic typed;
    pid_result_t res;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [pidc_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;

  pidc_in_if #(.VALUE_WIDTH(VW)) in_if ();
  pidc_out_if #(.VALUE_WIDTH(VW)) out_if ();

  pid_controller_clamped_unit #(.VALUE_WIDTH(VW), .GAIN_WIDTH(GW)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .in_if(in_if.sink), .out_if(out_if.source)
  );

  // Mirror of the controller registers and state.
  longint unsigned kp, ki, kd, period;
  bit rev;
  longint lim_lo, lim_hi;
  bit mode_on, first_due;
  longint integ_acc, last_meas;
  logic [TW-1:0] last_ms;

  pid_result_t drive_q[$];
  int unsigned fail_cnt = 0;
  int burst_left = 0;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic longint clamp_out(longint v);
    if (v > lim_hi) return lim_hi;
    if (v < lim_lo) return lim_lo;
    return v;
  endfunction

  // Sign-magnitude gain product with saturated magnitude.
  function automatic longint gain_mul(longint x, longint unsigned g);
    longint unsigned mag, hi, lo, p;
    bit neg;
    neg = (x < 0);
    mag = neg ? longint'(-x) : longint'(x);
    hi = mag * (g >> pidc_pkg::FRAC_BITS);
    lo = (mag * (g & 64'hFFFF)) >> pidc_pkg::FRAC_BITS;
    if (hi >= MAG_LIMIT) p = MAG_LIMIT;
    else begin
      p = hi + lo;
      if (p > MAG_LIMIT) p = MAG_LIMIT;
    end
    if (rev) neg = !neg;
    return neg ? -longint'(p) : longint'(p);
  endfunction

  // Advances the controller mirror by one item and returns its result.
  function automatic pid_result_t pid_update(pid_item_t it);
    pid_result_t r;
    logic [TW-1:0] elapsed;
    longint unsigned dt;
    longint err, deriv, meas;
    r = '0;
    meas = it.meas;
    if (it.kind == K_AUTO) begin
      if (!mode_on) begin
        integ_acc = clamp_out(longint'(it.man));
        last_meas = meas;
      end
      mode_on = 1'b1;
    end else if (it.kind == K_MANUAL) begin
      mode_on = 1'b0;
    end else if (it.kind == K_SAMPLE && mode_on) begin
      elapsed = it.now - last_ms;
      if (first_due || longint'(elapsed) >= period) begin
        dt = first_due ? period : longint'(elapsed);
        if (dt == 0) dt = 1;
        err = longint'(it.sp) - meas;
        deriv = (meas - last_meas) / longint'(dt);
        integ_acc = clamp_out(integ_acc + gain_mul(err, ki));
        r.drive = VW'(clamp_out(gain_mul(err, kp) + integ_acc - gain_mul(deriv, kd)));
        last_meas = meas;
        last_ms = it.now;
        first_due = 1'b0;
        r.updated = 1'b1;
      end
    end
    r.mode_auto = mode_on;
    return r;
  endfunction

  task automatic reg_write(pidc_pkg::cfg_idx_e idx, logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      pidc_pkg::CFG_PROP: kp = val[GW-1:0];
      pidc_pkg::CFG_INTEG: ki = val[GW-1:0];
      pidc_pkg::CFG_DERIV: kd = val[GW-1:0];
      pidc_pkg::CFG_LOW: lim_lo = longint'($signed(val[VW-1:0]));
      pidc_pkg::CFG_HIGH: lim_hi = longint'($signed(val[VW-1:0]));
      pidc_pkg::CFG_PERIOD: period = val[PW-1:0];
      pidc_pkg::CFG_REV: rev = val[0];
      default: ;
    endcase
  endtask

  task automatic write_all(logic [GW-1:0] p, logic [GW-1:0] i, logic [GW-1:0] d,
                           logic [VW-1:0] lo, logic [VW-1:0] hi,
                           logic [PW-1:0] per, logic r);
    reg_write(pidc_pkg::CFG_PROP, CFG_W'(p));
    reg_write(pidc_pkg::CFG_INTEG, CFG_W'(i));
    reg_write(pidc_pkg::CFG_DERIV, CFG_W'(d));
    reg_write(pidc_pkg::CFG_LOW, CFG_W'(lo));
    reg_write(pidc_pkg::CFG_HIGH, CFG_W'(hi));
    reg_write(pidc_pkg::CFG_PERIOD, CFG_W'(per));
    reg_write(pidc_pkg::CFG_REV, CFG_W'(r));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Waits for every outstanding result and lets the block settle.
  task automatic wait_idle();
    while (drive_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Sends one item in random bursts; typed rows override the prediction.
  task automatic send_item(pid_item_t it, bit typed, pid_result_t typed_res);
    pid_result_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if (in_if.valid) in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    if (!in_if.valid) @(posedge clk_i);
    in_if.valid <= 1'b1;
    in_if.kind <= it.kind;
    in_if.now_ms <= it.now;
    in_if.measurement <= it.meas;
    in_if.setpoint <= it.sp;
    in_if.manual_output <= it.man;
    do @(posedge clk_i); while (!in_if.ready);
    r = pid_update(it);
    drive_q.push_back(typed ? typed_res : r);
    burst_left--;
  endtask

  task automatic end_burst();
    if (in_if.valid) in_if.valid <= 1'b0;
    burst_left = 0;
  endtask

  function automatic logic [VW-1:0] rand_value();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return VAL_MAX;
      2: return VAL_MIN;
      default: return $signed($urandom_range(0, 26214400)) - 32'sd13107200;
    endcase
  endfunction

  function automatic logic [GW-1:0] rand_gain();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return GAIN_MAX;
      2: return GW'($urandom());
      default: return GW'($urandom_range(0, 4 * 65536));
    endcase
  endfunction

  // Receiver: stalls on a changing pattern and checks every result.
  int unsigned rx_cyc = 0;
  int unsigned stall_mode = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    pid_result_t e;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      rx_cyc++;
      if (rx_cyc % 256 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= ($urandom_range(0, 3) != 0);
        2: out_if.ready <= (rx_cyc % 7 < 3);
        default: out_if.ready <= ($urandom_range(0, 9) == 0);
      endcase
      if (out_if.valid && out_if.ready) begin
        if (drive_q.size() == 0) begin
          $error("result transaction with no expectation waiting");
          fail_cnt++;
        end else begin
          e = drive_q.pop_front();
          if (out_if.drive !== e.drive) begin
            $error("drive: expected %0d, actual %0d", e.drive, out_if.drive);
            fail_cnt++;
          end
          if (out_if.updated !== e.updated) begin
            $error("updated: expected %0b, actual %0b", e.updated, out_if.updated);
            fail_cnt++;
          end
          if (out_if.automatic_res !== e.mode_auto) begin
            $error("automatic_res: expected %0b, actual %0b", e.mode_auto,
                   out_if.automatic_res);
            fail_cnt++;
          end
        end
      end
    end
  end

  initial begin
    #30_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    stim_row_t rows[$];
    pid_item_t it;
    logic [TW-1:0] t;
    logic [VW-1:0] lo, hi, a, b;
    logic [PW-1:0] per;
    int sel;

    cfg_we_i = 1'b0;
    cfg_idx_i = pidc_pkg::CFG_PROP;
    cfg_data_i = '0;
    in_if.valid = 1'b0;
    in_if.kind = K_SAMPLE;
    in_if.now_ms = '0;
    in_if.measurement = '0;
    in_if.setpoint = '0;
    in_if.manual_output = '0;
    rst_ni = 1'b0;

    // Mirror of the reset state.
    kp = pidc_pkg::PROP_RST; ki = 0; kd = 0; lim_lo = 0; lim_hi = pidc_pkg::HIGH_RST;
    period = pidc_pkg::PERIOD_RST; rev = 1'b0;
    mode_on = 1'b0; first_due = 1'b1; integ_acc = 0; last_meas = 0; last_ms = '0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows at reset configuration.
    rows.push_back('{'{K_SAMPLE, 32'd0, 32'sd0, 32'sd0, 32'sd0}, 1'b1, '{0, 1'b0, 1'b0}});
    rows.push_back('{'{KIND_SPARE, 32'd1, 32'sd5, 32'sd5, 32'sd5}, 1'b1, '{0, 1'b0, 1'b0}});
    rows.push_back('{'{K_AUTO, 32'd2, 32'sd0, 32'sd0, 32'sd655360}, 1'b1,
                     '{0, 1'b0, 1'b1}});
    rows.push_back('{'{K_AUTO, 32'd3, 32'sd7, 32'sd0, 32'sd0}, 1'b1, '{0, 1'b0, 1'b1}});
    // First sample updates at once: 20.0 error at unity gain plus a 10.0 integral.
    rows.push_back('{'{K_SAMPLE, 32'd5, 32'sd0, 32'sd1310720, 32'sd0}, 1'b1,
                     '{32'sd1966080, 1'b1, 1'b1}});
    rows.push_back('{'{K_SAMPLE, 32'd50, 32'sd0, 32'sd1310720, 32'sd0}, 1'b1,
                     '{0, 1'b0, 1'b1}});
    rows.push_back('{'{K_SAMPLE, 32'd105, VAL_MIN, VAL_MAX, 32'sd0}, 1'b1,
                     '{HIGH_VAL, 1'b1, 1'b1}});
    rows.push_back('{'{K_SAMPLE, 32'd205, VAL_MAX, VAL_MIN, 32'sd0}, 1'b1,
                     '{0, 1'b1, 1'b1}});
    rows.push_back('{'{KIND_SPARE, 32'd206, 32'sd0, 32'sd0, 32'sd0}, 1'b1,
                     '{0, 1'b0, 1'b1}});
    rows.push_back('{'{K_SAMPLE, 32'hFFFF_FFF0, 32'sd65536, 32'sd131072, 32'sd0},
                     1'b0, '0});
    rows.push_back('{'{K_SAMPLE, 32'd90, 32'sd0, 32'sd65536, 32'sd0}, 1'b0, '0});
    rows.push_back('{'{K_MANUAL, 32'd91, 32'sd0, 32'sd0, 32'sd0}, 1'b1, '{0, 1'b0, 1'b0}});
    rows.push_back('{'{K_SAMPLE, 32'd500, 32'sd0, 32'sd65536, 32'sd0}, 1'b1,
                     '{0, 1'b0, 1'b0}});
    rows.push_back('{'{K_AUTO, 32'd501, 32'sd3, 32'sd0, VAL_MAX}, 1'b0, '0});
    rows.push_back('{'{K_SAMPLE, 32'd502, 32'sd3, 32'sd3, 32'sd0}, 1'b0, '0});
    foreach (rows[i]) send_item(rows[i].item, rows[i].typed, rows[i].res);
    end_burst();
    wait_idle();

    // Extreme gains, inverted limits, zero period and reverse action.
    write_all(GAIN_MAX, GAIN_MAX, GAIN_MAX, VAL_MAX, VAL_MIN, '0, 1'b1);
    rows.delete();
    rows.push_back('{'{K_MANUAL, 32'd0, 32'sd0, 32'sd0, 32'sd0}, 1'b0, '0});
    rows.push_back('{'{K_AUTO, 32'd0, VAL_MIN, 32'sd0, VAL_MIN}, 1'b0, '0});
    rows.push_back('{'{K_SAMPLE, 32'd0, VAL_MAX, VAL_MIN, 32'sd0}, 1'b0, '0});
    rows.push_back('{'{K_SAMPLE, 32'd0, VAL_MIN, VAL_MAX, 32'sd0}, 1'b0, '0});
    rows.push_back('{'{K_SAMPLE, 32'd1, VAL_MAX, VAL_MAX, 32'sd0}, 1'b0, '0});
    foreach (rows[i]) send_item(rows[i].item, rows[i].typed, rows[i].res);
    end_burst();
    wait_idle();

    // Random phases, each under a fresh configuration.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      sel = $urandom_range(0, 3);
      a = rand_value();
      b = rand_value();
      if (sel == 0) begin
        lo = VAL_MIN; hi = VAL_MAX;
      end else if (sel == 1) begin
        lo = b; hi = a;
      end else begin
        lo = ($signed(a) < $signed(b)) ? a : b;
        hi = ($signed(a) < $signed(b)) ? b : a;
      end
      case ($urandom_range(0, 4))
        0: per = '0;
        1: per = 16'd1;
        2: per = '1;
        default: per = 16'($urandom_range(1, 300));
      endcase
      write_all(rand_gain(), rand_gain(), rand_gain(), lo, hi, per,
                1'($urandom_range(0, 1)));
      t = ($urandom_range(0, 1) != 0) ? $urandom() : 32'hFFFF_FF00;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        sel = $urandom_range(0, 99);
        if (sel < 6) it.kind = K_AUTO;
        else if (sel < 9) it.kind = K_MANUAL;
        else if (sel < 11) it.kind = KIND_SPARE;
        else it.kind = K_SAMPLE;
        if (n == 0) it.kind = K_AUTO;
        t = t + TW'($urandom_range(0, 32'(2 * period + 2)));
        it.now = ($urandom_range(0, 40) == 0) ? $urandom() : t;
        it.meas = rand_value();
        it.sp = rand_value();
        it.man = rand_value();
        send_item(it, 1'b0, '0);
      end
      end_burst();
      wait_idle();
    end

    while (drive_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
